/* rtl/core/pcmdth_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmdth_pkg
// Shared types and constants for the 24-to-16 bit PCM dither block.
// ----------------------------------------------------------------------------
package pcmdth_pkg;

    localparam int SampleInW  = 32;
    localparam int NoiseW     = 8;
    localparam int SampleOutW = 16;
    localparam int ErrW       = 12;
    localparam int InDataW    = 40;   // sample_in + noise_word, whole bytes
    localparam int OutDataW   = 16;
    localparam int ShapedW    = 34;   // shaped sample, no overflow
    localparam int WideW      = 35;   // rounded and dithered sum

    localparam logic signed [WideW-1:0] FULL_MAX  = 35'sd8388607;
    localparam logic signed [WideW-1:0] FULL_MIN  = -35'sd8388608;
    localparam logic signed [WideW-1:0] ROUND_ADD = 35'sd128;

    typedef logic signed [ErrW-1:0] err_t;

    // error feedback history and the last noise byte
    typedef struct packed {
        err_t              e0;
        err_t              e1;
        err_t              e2;
        logic [NoiseW-1:0] prev_noise;
    } fb_state_t;

    // one quantized result and the new error it leaves behind
    typedef struct packed {
        logic signed [SampleOutW-1:0] sample_out;
        err_t                         err_new;
        logic [NoiseW-1:0]            noise;
    } quant_res_t;

endpackage

/* rtl/core/pcmdth_quant.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmdth_quant
// Single-pass shaping, rounding, dither, clip and quantization of one sample.
// ----------------------------------------------------------------------------
module pcmdth_quant (
    input  logic                                    source_is_32_bit,
    input  logic signed [pcmdth_pkg::SampleInW-1:0] sample_in,
    input  logic [pcmdth_pkg::NoiseW-1:0]           noise_word,
    input  pcmdth_pkg::fb_state_t                   fb,
    output pcmdth_pkg::quant_res_t                  res
);
    import pcmdth_pkg::*;

    logic signed [ShapedW-1:0] samp_sel;
    logic signed [ShapedW-1:0] fb_sum;
    logic signed [ShapedW-1:0] shaped;
    logic signed [WideW-1:0]   shaped_w;
    logic signed [WideW-1:0]   dith;
    logic signed [WideW-1:0]   out_sum;
    logic signed [WideW-1:0]   shaped_c;
    logic signed [WideW-1:0]   out_q;
    logic signed [WideW-1:0]   err_w;
    logic                      clip_hi;
    logic                      clip_lo;
    logic [23:0]               out_clip;

    always_comb
    begin
        // 32-bit source: arithmetic shift right by 8
        if (source_is_32_bit)
        begin
            samp_sel = ShapedW'(signed'(sample_in[SampleInW-1:8]));
        end
        else
        begin
            samp_sel = ShapedW'(sample_in);
        end

        fb_sum   = ShapedW'(fb.e0) - ShapedW'(fb.e1) + ShapedW'(fb.e2);
        shaped   = samp_sel + fb_sum;
        shaped_w = WideW'(shaped);

        // triangular dither from two successive noise bytes
        dith    = WideW'(signed'({1'b0, noise_word})) - WideW'(signed'({1'b0, fb.prev_noise}));
        out_sum = shaped_w + ROUND_ADD + dith;

        clip_hi  = out_sum > FULL_MAX;
        clip_lo  = out_sum < FULL_MIN;
        shaped_c = shaped_w;
        if (clip_hi)
        begin
            out_clip = 24'h7F_FFFF;
            if (shaped_w > FULL_MAX)
            begin
                shaped_c = FULL_MAX;
            end
        end
        else if (clip_lo)
        begin
            out_clip = 24'h80_0000;
            if (shaped_w < FULL_MIN)
            begin
                shaped_c = FULL_MIN;
            end
        end
        else
        begin
            out_clip = out_sum[23:0];
        end

        // drop the low byte
        out_q = WideW'(signed'({out_clip[23:8], 8'h00}));
        err_w = shaped_c - out_q;

        res.sample_out = out_clip[23:8];
        res.err_new    = err_w[ErrW-1:0];
        res.noise      = noise_word;
    end

endmodule

/* rtl/core/pcmdth_err_fb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmdth_err_fb
// Error feedback history e0/e1/e2 and previous noise byte.
// ----------------------------------------------------------------------------
module pcmdth_err_fb (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  pcmdth_pkg::quant_res_t res,
    output pcmdth_pkg::fb_state_t  fb
);
    import pcmdth_pkg::*;

    fb_state_t fb_reg;
    fb_state_t fb_next;
    err_t      half;

    always_comb
    begin
        // halve toward zero
        half = (fb_reg.e0 + err_t'(fb_reg.e0[ErrW-1])) >>> 1;
        fb_next            = fb_reg;
        fb_next.e0         = res.err_new;
        fb_next.e1         = half;
        fb_next.e2         = fb_reg.e1;
        fb_next.prev_noise = res.noise;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_reg <= '0;
        end
        else if (advance)
        begin
            fb_reg <= fb_next;
        end
    end

    assign fb = fb_reg;

endmodule

/* rtl/core/pcm_dither_24_to_16.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_dither_24_to_16
// Noise-shaped TPDF dither from 24-bit or 32-bit PCM down to 16 bits.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input request is held in the input reg, then its result
// in the result reg. Throughput: one sample per cycle unless the output stalls;
// the error feedback registers update together with the result reg.
// Reset: rst_n asynchronous, active low; clears valids, mode and error history.
// ----------------------------------------------------------------------------
module pcm_dither_24_to_16 (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pcmdth_pkg::InDataW-1:0]      s_axis_tdata,  // sample_in[31:0], noise_word[39:32]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pcmdth_pkg::OutDataW-1:0]     m_axis_tdata   // sample_out[15:0]
);
    import pcmdth_pkg::*;

    logic                  mode_reg;
    logic                  in_valid_reg;
    logic [InDataW-1:0]    in_data_reg;
    logic                  out_valid_reg;
    logic [OutDataW-1:0]   out_data_reg;
    logic                  advance;
    fb_state_t             fb;
    quant_res_t            res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_data_reg <= res.sample_out;
        end
    end

    pcmdth_quant u_quant (
        .source_is_32_bit (mode_reg),
        .sample_in        (in_data_reg[SampleInW-1:0]),
        .noise_word       (in_data_reg[SampleInW +: NoiseW]),
        .fb               (fb),
        .res              (res)
    );

    pcmdth_err_fb u_err_fb (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .res     (res),
        .fb      (fb)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* rtl/core/pcmdth_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmdth_checker
// Port-level checks on the dither block's stream behavior.
// ----------------------------------------------------------------------------
module pcmdth_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [pcmdth_pkg::OutDataW-1:0]    m_axis_tdata
);
    import pcmdth_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // input backpressure only from a full, stalled result register
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // a new result follows an accepted request, through the input reg and the result reg
    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result appeared without a request");

endmodule

bind pcm_dither_24_to_16 pcmdth_checker u_pcmdth_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* verif/pcm_dither_24_to_16_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_dither_24_to_16_checker
// Watches both stream channels and the mode register of the dither block,
// predicts each 16-bit output from the accepted input request and compares
// it with what the block delivers.
// ----------------------------------------------------------------------------
module pcm_dither_24_to_16_checker
    import pcmdth_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // sample_in[31:0], noise_word[39:32]
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [OutDataW-1:0] m_axis_tdata,   // sample_out[15:0]
    input  logic                end_check,
    output int                  pending,
    output int                  fail_count
);

    logic              mode_32;
    err_t              err_now;
    err_t              err_half;
    err_t              err_old;
    logic [NoiseW-1:0] last_noise;
    bit                end_seen;

    logic signed [SampleOutW-1:0] expected_pcm16[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        end_seen   = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch #%0d: %s", $time, fail_count, msg);
    endtask

    // Shape, dither, clip and quantize one sample; advance the error history.
    function automatic logic signed [SampleOutW-1:0] dither_step(
        input logic signed [SampleInW-1:0] raw,
        input logic [NoiseW-1:0]           nz
    );
        longint shaped;
        longint level;
        shaped = mode_32 ? longint'(raw >>> 8) : longint'(raw);
        shaped += longint'(err_now) - longint'(err_half) + longint'(err_old);
        err_old  = err_half;
        err_half = err_t'(err_now / 2);
        level = shaped + longint'(ROUND_ADD) + longint'(nz) - longint'(last_noise);
        last_noise = nz;
        if (level > longint'(FULL_MAX))
        begin
            level = longint'(FULL_MAX);
            if (shaped > longint'(FULL_MAX))
                shaped = longint'(FULL_MAX);
        end
        else if (level < longint'(FULL_MIN))
        begin
            level = longint'(FULL_MIN);
            if (shaped < longint'(FULL_MIN))
                shaped = longint'(FULL_MIN);
        end
        level   = level & ~longint'(255);
        err_now = err_t'(shaped - level);
        return level[23:8];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [SampleOutW-1:0] want;
        if (!rst_n)
        begin
            mode_32    = 1'b0;
            err_now    = '0;
            err_half   = '0;
            err_old    = '0;
            last_noise = '0;
            expected_pcm16.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                mode_32 = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                expected_pcm16.push_back(dither_step(s_axis_tdata[SampleInW-1:0],
                                                     s_axis_tdata[InDataW-1:SampleInW]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pcm16.size() == 0)
                    report_mismatch($sformatf("sample_out %0d with no request pending",
                                              $signed(m_axis_tdata)));
                else
                begin
                    want = expected_pcm16.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch($sformatf("sample_out got %0d (0x%h) want %0d",
                                                  $signed(m_axis_tdata), m_axis_tdata, want));
                end
            end
            if (end_check && !end_seen)
            begin
                end_seen = 1'b1;
                if (expected_pcm16.size() != 0)
                    report_mismatch($sformatf("%0d outputs never delivered",
                                              expected_pcm16.size()));
            end
            pending <= expected_pcm16.size();
        end
    end

endmodule

/* verif/pcm_dither_24_to_16_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_dither_24_to_16_tb
// Drives directed and random PCM samples through the dither block in both
// source widths, with random idle gaps and a long output stall, and lets the
// checker compare every 16-bit output against its own prediction.
// ----------------------------------------------------------------------------
module pcm_dither_24_to_16_tb;
    import pcmdth_pkg::*;

    localparam int PhaseItems = 425;
    localparam int LongHold   = 300;
    localparam int CycleLimit = 600000;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    logic                cfg_wdata     = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic [InDataW-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tready = 1'b0;
    logic                end_check     = 1'b0;
    wire                 s_axis_tready;
    wire                 m_axis_tvalid;
    wire [OutDataW-1:0]  m_axis_tdata;
    int                  pending;
    int                  fail_count;
    int                  cycle_count   = 0;
    bit                  calm          = 1'b0;
    bit                  long_hold_req = 1'b0;

    pcm_dither_24_to_16 u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pcm_dither_24_to_16_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .end_check     (end_check),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // mostly short idles, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic signed [SampleInW-1:0] pick_sample(input bit wide);
        int unsigned                 r;
        logic signed [SampleInW-1:0] v;
        r = $urandom_range(99);
        if (r < 10)
            return $urandom;
        if (r < 20)
            v = 8388607 - int'($urandom_range(600));
        else if (r < 30)
            v = -8388608 + int'($urandom_range(600));
        else if (r < 40)
            v = int'($urandom_range(4000)) - 2000;
        else
            v = $signed($urandom) >>> 8;
        if (wide)
            v = {v[23:0], 8'($urandom_range(255))};
        return v;
    endfunction

    function automatic logic [NoiseW-1:0] pick_noise();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return NoiseW'($urandom_range(255));
    endfunction

    task automatic send_pcm(input logic signed [SampleInW-1:0] smp,
                            input logic [NoiseW-1:0] nz);
        int gap;
        gap = (calm || $urandom_range(99) < 60) ? 0 : idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nz, smp};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // drop valid and wait until every output has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_source_width(input bit wide);
        cfg_we    <= 1'b1;
        cfg_wdata <= wide;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // output side: random stalls, plus one long hold on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LongHold;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (!calm && $urandom_range(99) < 20)
            begin
                hold_left = idle_len() - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int phase;
        int i;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 24-bit source: extremes, clipping both ways, out-of-range words
        set_source_width(1'b0);
        send_pcm(32'sd0, 8'd0);
        send_pcm(32'sd8388607, 8'd255);
        send_pcm(32'sd8388607, 8'd0);
        send_pcm(-32'sd8388608, 8'd0);
        send_pcm(-32'sd8388608, 8'd255);
        send_pcm(32'h7FFF_FFFF, 8'd255);
        send_pcm(32'h8000_0000, 8'd0);
        send_pcm(-32'sd1, 8'd128);
        send_pcm(32'sd1000, 8'd37);
        send_pcm(-32'sd8388400, 8'd0);
        send_pcm(32'sd8388400, 8'd255);
        send_pcm(32'h00FF_FFFF, 8'h55);
        send_pcm(32'hFF00_0000, 8'hAA);
        drain();

        // 32-bit source: full-scale words and the floor shift of negatives
        set_source_width(1'b1);
        send_pcm(32'h7FFF_FFFF, 8'd255);
        send_pcm(32'h8000_0000, 8'd0);
        send_pcm(-32'sd1, 8'd0);
        send_pcm(32'sd255, 8'd255);
        send_pcm(-32'sd256, 8'd1);
        send_pcm(32'sd0, 8'd0);
        send_pcm(32'h7FFF_FF80, 8'd200);
        send_pcm(32'h5A5A_5A5A, 8'hA5);
        send_pcm(32'hA5A5_A5A5, 8'h5A);

        for (phase = 0; phase < 4; phase++)
        begin
            drain();
            set_source_width(phase[0]);
            calm = (phase == 2);
            for (i = 0; i < PhaseItems; i++)
            begin
                if (phase == 0 && i == 60)
                    long_hold_req = 1'b1;
                send_pcm(pick_sample(phase[0]), pick_noise());
            end
        end
        drain();
        repeat (8) @(posedge clk);
        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
